// ===== rtl/prf_pkg.sv =====
package prf_pkg;

    localparam int VALUE_BITS_DEFAULT = 63;
    localparam int LCG_BITS = 48;
    localparam logic [47:0] LCG_MUL = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD = 48'h0000_0000_000B;
    localparam logic [47:0] LCG_SEED = 48'h1234_ABCD_330E;
    localparam int MIN_ATTEMPTS = 3;
    localparam int MIN_ITERATIONS = 1000;
    localparam int BASE_EXP = 18;
    localparam int MAX_EXP = 30;
    localparam int OFFSET_BASE = 17;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RAND_T,
        ST_RAND_T_WAIT,
        ST_MOD_T,
        ST_MOD_T_WAIT,
        ST_RAND_X,
        ST_RAND_X_WAIT,
        ST_MOD_X,
        ST_MOD_X_WAIT,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_DIFF,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_CHECK,
        ST_ATTEMPT_END,
        ST_QUOT_START,
        ST_QUOT_WAIT,
        ST_DONE,
        ST_OUT
    } prf_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RAND,
        OP_MOD,
        OP_SQUARE,
        OP_GCD,
        OP_DIV
    } prf_op_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        prf_op_t    op;
        logic       start;
        logic       mod_is_x;
        logic       set_t;
        logic       set_x;
        logic       set_y;
        logic       set_diff;
        logic       clear_out;
        logic       set_out;
    } prf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic small_value;
        logic g_is_one;
        logic g_found;
    } prf_stat_t;

endpackage

// ===== rtl/prf_datapath.sv =====
module prf_datapath
    import prf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  prf_cmd_t              cmd,
    input  logic                  load_g,
    output prf_stat_t             stat,
    output logic [31:0]           small_factor,
    output logic [31:0]           large_factor,
    output logic                  found
);

    localparam int W = VALUE_BITS;
    // dividend shift register holds either a 31-bit draw or the value
    localparam int DW = (W + 1 > 31) ? W + 1 : 31;
    localparam int CW = $clog2(DW + 1);

    logic [W-1:0] n_reg, t_reg, x_reg, y_reg, diff_reg;
    logic [W-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [DW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    prf_op_t      op_reg, op_next;
    logic         busy_reg, busy_next;
    logic [LCG_BITS-1:0] rs_reg, rs_next;
    logic [LCG_BITS-1:0] ra_reg, ra_next;
    logic [30:0]  draw_reg;
    logic [31:0]  sf_reg, lf_reg;
    logic         found_reg;

    logic [W:0]   sum_a, rem_sh;
    logic [W-1:0] nm1;
    logic [30:0]  mod_src;
    logic [31:0]  p32, q32;

    assign nm1 = n_reg - {{(W-1){1'b0}}, 1'b1};
    assign sum_a = {1'b0, a_reg} + {1'b0, b_reg};
    assign rem_sh = {a_reg, q_reg[DW-1]};
    // offset is reduced as (low four bits + 17) mod n, start point as draw mod (n - 1)
    assign mod_src = cmd.mod_is_x ? draw_reg : 31'(draw_reg[3:0]) + 31'(OFFSET_BASE);

    // iterative unit: lcg multiply, restoring mod/div, shift-add square, odd gcd
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        busy_next = busy_reg;
        rs_next = rs_reg;
        ra_next = ra_reg;
        if (cmd.start)
        begin
            op_next = cmd.op;
            busy_next = 1'b1;
            unique case (cmd.op)
                OP_RAND:
                begin
                    ra_next = '0;
                    cnt_next = '0;
                end
                OP_MOD:
                begin
                    // remainder of draw by divisor, one bit a step
                    a_next = '0;
                    q_next = DW'(mod_src) << (DW - 31);
                    b_next = cmd.mod_is_x ? nm1 : n_reg;
                    cnt_next = CW'(31);
                end
                OP_DIV:
                begin
                    a_next = '0;
                    q_next = DW'({1'b0, n_reg}) << (DW - W - 1);
                    b_next = x_reg;
                    cnt_next = CW'(W + 1);
                end
                OP_SQUARE:
                begin
                    a_next = t_reg;
                    b_next = x_reg;
                    c_next = x_reg;
                end
                OP_GCD:
                begin
                    a_next = diff_reg;
                    b_next = n_reg;
                end
                default: busy_next = 1'b0;
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_RAND:
                begin
                    // 48x48 product truncated, 12 bits of multiplier per step
                    ra_next = ra_reg + (rs_reg * {36'd0, LCG_MUL[cnt_reg[1:0]*12 +: 12]}
                        << (cnt_reg[1:0] * 12));
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        rs_next = ra_next + LCG_ADD;
                        busy_next = 1'b0;
                    end
                end
                OP_MOD, OP_DIV:
                begin
                    if (rem_sh >= {1'b0, b_reg})
                    begin
                        a_next = W'(rem_sh - {1'b0, b_reg});
                        q_next = {q_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        a_next = W'(rem_sh);
                        q_next = {q_reg[DW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        busy_next = 1'b0;
                end
                OP_SQUARE:
                begin
                    // a = acc, b = addend, c = remaining bits
                    if (c_reg == '0)
                        busy_next = 1'b0;
                    else
                    begin
                        if (c_reg[0])
                            a_next = (sum_a >= {1'b0, n_reg}) ? W'(sum_a - {1'b0, n_reg})
                                                               : W'(sum_a);
                        b_next = (({1'b0, b_reg} << 1) >= {1'b0, n_reg})
                            ? W'(({1'b0, b_reg} << 1) - {1'b0, n_reg}) : W'({1'b0, b_reg} << 1);
                        c_next = c_reg >> 1;
                    end
                end
                OP_GCD:
                begin
                    // a = u, b = v
                    if (a_reg == '0 || b_reg == '0)
                    begin
                        busy_next = 1'b0;
                        if (b_reg == '0)
                            b_next = a_reg;
                    end
                    else if (!b_reg[0])
                        b_next = b_reg >> 1;
                    else if (!a_reg[0])
                        a_next = a_reg >> 1;
                    else if (a_reg > b_reg)
                        a_next = a_reg - b_reg;
                    else
                        b_next = b_reg - a_reg;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg <= OP_NONE;
            rs_reg <= LCG_SEED;
            found_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg <= op_next;
            rs_reg <= rs_next;
            if (cmd.clear_out)
                found_reg <= 1'b0;
            else if (cmd.set_out)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        q_reg <= q_next;
        cnt_reg <= cnt_next;
        ra_reg <= ra_next;
        if (op_reg == OP_RAND && busy_reg && !busy_next)
            draw_reg <= rs_next[47:17];
        if (cmd.load)
            n_reg <= value;
        if (cmd.set_t)
            t_reg <= a_reg;
        if (load_g)
            x_reg <= b_reg;
        else if (cmd.set_x)
            x_reg <= cmd.mod_is_x ? a_reg + {{(W-1){1'b0}}, 1'b1} : a_reg;
        if (cmd.set_y)
            y_reg <= cmd.set_x ? a_reg + {{(W-1){1'b0}}, 1'b1} : x_reg;
        if (cmd.set_diff)
            diff_reg <= (x_reg < y_reg) ? n_reg + x_reg - y_reg : x_reg - y_reg;
        if (cmd.clear_out)
        begin
            sf_reg <= '0;
            lf_reg <= '0;
        end
        else if (cmd.set_out)
        begin
            sf_reg <= (p32 > q32) ? q32 : p32;
            lf_reg <= (p32 > q32) ? p32 : q32;
        end
    end

    // x_reg holds g during the final division
    assign p32 = 32'(x_reg);
    assign q32 = 32'(q_reg);

    assign stat.busy = busy_reg;
    assign stat.small_value = (n_reg < W'(2));
    assign stat.g_is_one = (b_reg == {{(W-1){1'b0}}, 1'b1});
    assign stat.g_found = (b_reg > {{(W-1){1'b0}}, 1'b1}) && (b_reg < n_reg);

    assign small_factor = sf_reg;
    assign large_factor = lf_reg;
    assign found = found_reg;

endmodule

// ===== rtl/prf_control.sv =====
module prf_control
    import prf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  prf_stat_t stat,
    output prf_cmd_t  cmd,
    output logic      use_b_as_g
);

    prf_state_t state_reg, state_next;
    logic [4:0]  att_reg, att_next;
    logic [30:0] j_reg, j_next;
    logic [9:0]  it_reg, it_next;
    logic        itdone_reg, itdone_next;
    logic [30:0] lim;
    logic [4:0]  e;

    assign e = (att_reg > 5'(MAX_EXP - BASE_EXP)) ? 5'(MAX_EXP) : 5'(att_reg + 5'(BASE_EXP));
    assign lim = 31'(32'd1 << e);
    assign use_b_as_g = (state_reg == ST_QUOT_START);

    always_comb
    begin
        state_next = state_reg;
        att_next = att_reg;
        j_next = j_reg;
        it_next = it_reg;
        itdone_next = itdone_reg;
        cmd = '0;
        cmd.op = OP_NONE;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clear_out = 1'b1;
                    att_next = '0;
                    it_next = '0;
                    itdone_next = 1'b0;
                    state_next = ST_RAND_T;
                end
            end
            ST_RAND_T:
            begin
                if (stat.small_value)
                    state_next = ST_OUT;
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op = OP_RAND;
                    state_next = ST_RAND_T_WAIT;
                end
            end
            ST_RAND_T_WAIT: if (!stat.busy) state_next = ST_MOD_T;
            ST_MOD_T:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_MOD;
                state_next = ST_MOD_T_WAIT;
            end
            ST_MOD_T_WAIT:
                if (!stat.busy)
                begin
                    // remainder is already ((draw & 15) + 17) mod n
                    cmd.set_t = 1'b1;
                    state_next = ST_RAND_X;
                end
            ST_RAND_X:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_RAND;
                state_next = ST_RAND_X_WAIT;
            end
            ST_RAND_X_WAIT: if (!stat.busy) state_next = ST_MOD_X;
            ST_MOD_X:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_MOD;
                cmd.mod_is_x = 1'b1;
                state_next = ST_MOD_X_WAIT;
            end
            ST_MOD_X_WAIT:
                if (!stat.busy)
                begin
                    cmd.mod_is_x = 1'b1;
                    cmd.set_x = 1'b1;
                    cmd.set_y = 1'b1;
                    j_next = 31'd1;
                    state_next = (lim > 31'd1) ? ST_SQ_START : ST_ATTEMPT_END;
                end
            ST_SQ_START:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_SQUARE;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
                if (!stat.busy)
                begin
                    cmd.set_x = 1'b1;
                    if (!itdone_reg)
                    begin
                        it_next = it_reg + 1'b1;
                        if (it_reg == 10'(MIN_ITERATIONS - 1))
                            itdone_next = 1'b1;
                    end
                    state_next = ST_DIFF;
                end
            ST_DIFF:
            begin
                cmd.set_diff = 1'b1;
                state_next = ST_GCD_START;
            end
            ST_GCD_START:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_GCD;
                state_next = ST_GCD_WAIT;
            end
            ST_GCD_WAIT: if (!stat.busy) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!stat.g_is_one)
                    state_next = ST_ATTEMPT_END;
                else
                begin
                    if ((j_reg & (j_reg - 31'd1)) == '0)
                        cmd.set_y = 1'b1;
                    j_next = j_reg + 31'd1;
                    state_next = (j_reg + 31'd1 < lim) ? ST_SQ_START : ST_ATTEMPT_END;
                end
            end
            ST_ATTEMPT_END:
            begin
                if (stat.g_found)
                    state_next = ST_QUOT_START;
                else
                begin
                    att_next = (att_reg == 5'd31) ? att_reg : att_reg + 5'd1;
                    if (att_reg >= 5'(MIN_ATTEMPTS - 1) && itdone_reg)
                        state_next = ST_OUT;
                    else
                        state_next = ST_RAND_T;
                end
            end
            ST_QUOT_START:
            begin
                cmd.set_x = 1'b1;
                state_next = ST_QUOT_WAIT;
            end
            ST_QUOT_WAIT:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_DIV;
                state_next = ST_DONE;
            end
            ST_DONE:
                if (!stat.busy)
                begin
                    cmd.set_out = 1'b1;
                    state_next = ST_OUT;
                end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            att_reg <= '0;
            j_reg <= '0;
            it_reg <= '0;
            itdone_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            att_reg <= att_next;
            j_reg <= j_next;
            it_reg <= it_next;
            itdone_reg <= itdone_next;
        end
    end

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ_START |-> j_reg < lim)
        else $error("iteration past limit");

endmodule

// ===== rtl/pollard_rho_factorizer.sv =====
// flow: a value below two goes straight to the result; otherwise the rho loop runs,
// each iteration a shift-add square then an odd gcd; a found factor ends the search
// at once and adds a division, a failure runs at least 1000 iterations over at least
// 3 attempts
// throughput: one transaction at a time; next accepted in the cycle after the result is taken
// reset: asynchronous active low, lcg state returns to its default seed
module pollard_rho_factorizer
    import prf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           small_factor,
    output logic [31:0]           large_factor,
    output logic                  found
);

    prf_cmd_t  cmd, cmd_c;
    prf_stat_t stat;
    logic      use_b_as_g;

    prf_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stat       (stat),
        .cmd        (cmd_c),
        .use_b_as_g (use_b_as_g)
    );

    // g lands in b; load it into x for the division
    always_comb
    begin
        cmd = cmd_c;
        if (use_b_as_g)
            cmd.set_x = 1'b0;
    end

    prf_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .load_g       (use_b_as_g),
        .stat         (stat),
        .small_factor (small_factor),
        .large_factor (large_factor),
        .found        (found)
    );

endmodule
